// ===== design/ethernet_controller_register_file_unit_assert.svh =====
// Assertion macros for the ethernet controller register file
`ifndef ETHERNET_CONTROLLER_REGISTER_FILE_UNIT_ASSERT_SVH
`define ETHERNET_CONTROLLER_REGISTER_FILE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ECRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ECRF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ecrf_pkg.sv =====
// Shared constants and types of the ethernet controller register file
package ecrf_pkg;

    localparam int BUFFER_BYTES = 32768;
    localparam int BUFFER_BASE  = 16384;
    localparam int BUF_AW       = $clog2(BUFFER_BYTES);

    localparam logic [16:0] BUF_LO = 17'(BUFFER_BASE);
    localparam logic [16:0] BUF_HI = 17'(BUFFER_BASE + BUFFER_BYTES);

    localparam logic [4:0] ADDR_DATA0 = 5'h10;
    localparam logic [4:0] ADDR_DATA1 = 5'h11;
    localparam logic [4:0] ADDR_RESET = 5'h1F;

    localparam logic [1:0] PAGE0 = 2'd0;
    localparam logic [1:0] PAGE1 = 2'd1;
    localparam logic [1:0] PAGE2 = 2'd2;

    localparam logic [3:0] OFS_CR     = 4'h0;
    localparam logic [3:0] OFS_PSTART = 4'h1;
    localparam logic [3:0] OFS_PSTOP  = 4'h2;
    localparam logic [3:0] OFS_BNRY   = 4'h3;
    localparam logic [3:0] OFS_TPSR   = 4'h4;
    localparam logic [3:0] OFS_TBCR0  = 4'h5;
    localparam logic [3:0] OFS_TBCR1  = 4'h6;
    localparam logic [3:0] OFS_ISR    = 4'h7;
    localparam logic [3:0] OFS_RSAR0  = 4'h8;
    localparam logic [3:0] OFS_RSAR1  = 4'h9;
    localparam logic [3:0] OFS_RBCR0  = 4'hA;
    localparam logic [3:0] OFS_RBCR1  = 4'hB;
    localparam logic [3:0] OFS_RCR    = 4'hC;
    localparam logic [3:0] OFS_TCR    = 4'hD;
    localparam logic [3:0] OFS_DCR    = 4'hE;
    localparam logic [3:0] OFS_IMR    = 4'hF;

    localparam logic [7:0] CR_RESET  = 8'h21;
    localparam logic [7:0] ISR_RESET = 8'h80;
    localparam logic [7:0] ISR_RDC   = 8'h40;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [BUF_AW-1:0] idx;
        logic [7:0]        wdata;
    } t_buf_req;

endpackage

// ===== design/ecrf_buf.sv =====
// Packet buffer memory with power-on clearing sweep
module ecrf_buf
    import ecrf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_buf_req i_req,
    output logic [7:0] o_q,
    output logic     o_busy
);

    logic [7:0]        r_mem [BUFFER_BYTES];
    logic [7:0]        r_q;
    logic [BUF_AW-1:0] r_clr;
    logic              r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == '1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr] <= 8'h00;
        end else if (i_req.wr_en) begin
            r_mem[i_req.idx] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.idx];
        end
    end

    assign o_q    = r_q;
    assign o_busy = r_busy;

endmodule

// ===== design/ecrf_regs.sv =====
// Paged register file, remote DMA counters and result formation
module ecrf_regs
    import ecrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_command,
    input  logic [4:0] i_address,
    input  logic [7:0] i_write_data,
    output logic [7:0] o_read_data,
    output logic       o_use_mem,
    output logic       o_irq,
    output t_buf_req   o_req
);

    logic [7:0]  r_cr, r_pstart, r_pstop, r_bnry, r_tpsr, r_isr, r_curr, r_rnpp, r_lnpp;
    logic [15:0] r_tbcr, r_rsar, r_rbcr, r_crda, r_clda, r_actr;
    logic [5:0]  r_rcr, r_dcr;
    logic [4:0]  r_tcr;
    logic [6:0]  r_imr;
    logic [7:0]  r_sta [6];
    logic [7:0]  r_mar [8];

    logic [7:0]  n_cr, n_pstart, n_pstop, n_bnry, n_tpsr, n_isr, n_curr, n_rnpp, n_lnpp;
    logic [15:0] n_tbcr, n_rsar, n_rbcr, n_crda, n_clda, n_actr;
    logic [5:0]  n_rcr, n_dcr;
    logic [4:0]  n_tcr;
    logic [6:0]  n_imr;
    logic [7:0]  n_sta [6];
    logic [7:0]  n_mar [8];

    logic [3:0]  ofs;
    logic [1:0]  page;
    logic        is_port, dma_go, in_buf, soft_rst;
    logic [15:0] nxt_addr;
    logic [7:0]  rd;

    assign ofs      = i_address[3:0];
    assign page     = r_cr[7:6];
    assign is_port  = (i_address == ADDR_DATA0) || (i_address == ADDR_DATA1);
    assign dma_go   = is_port && (r_rbcr != 16'h0000) && !(i_address[0] && !r_dcr[0]);
    assign in_buf   = ({1'b0, r_crda} >= BUF_LO) && ({1'b0, r_crda} < BUF_HI);
    assign soft_rst = (i_address == ADDR_RESET) && !i_command;
    assign nxt_addr = r_crda + 16'h0001;

    always_comb begin
        n_cr = r_cr; n_pstart = r_pstart; n_pstop = r_pstop; n_bnry = r_bnry;
        n_tpsr = r_tpsr; n_isr = r_isr; n_curr = r_curr; n_rnpp = r_rnpp;
        n_lnpp = r_lnpp; n_tbcr = r_tbcr; n_rsar = r_rsar; n_rbcr = r_rbcr;
        n_crda = r_crda; n_clda = r_clda; n_actr = r_actr; n_rcr = r_rcr;
        n_dcr = r_dcr; n_tcr = r_tcr; n_imr = r_imr;
        n_sta = r_sta; n_mar = r_mar;
        rd = 8'h00;
        if (dma_go) begin
            n_crda = (nxt_addr == {r_pstop, 8'h00}) ? {r_pstart, 8'h00} : nxt_addr;
            n_rbcr = r_rbcr - 16'h0001;
            if (n_rbcr == 16'h0000) begin
                n_isr = r_isr | ISR_RDC;
            end
        end else if (soft_rst) begin
            n_cr = CR_RESET; n_pstart = '0; n_pstop = '0; n_bnry = '0; n_tpsr = '0;
            n_isr = ISR_RESET; n_curr = '0; n_rnpp = '0; n_lnpp = '0; n_tbcr = '0;
            n_rsar = '0; n_rbcr = '0; n_crda = '0; n_clda = '0; n_actr = '0;
            n_rcr = '0; n_dcr = '0; n_tcr = '0; n_imr = '0;
            for (int k = 0; k < 6; k++) n_sta[k] = '0;
            for (int k = 0; k < 8; k++) n_mar[k] = '0;
        end else if (!i_address[4]) begin
            if (i_command) begin
                if (ofs == OFS_CR) begin
                    n_cr = i_write_data;
                end else if (page == PAGE0) begin
                    case (ofs)
                        OFS_PSTART: n_pstart = i_write_data;
                        OFS_PSTOP:  n_pstop = i_write_data;
                        OFS_BNRY:   n_bnry = i_write_data;
                        OFS_TPSR:   n_tpsr = i_write_data;
                        OFS_TBCR0:  n_tbcr[7:0] = i_write_data;
                        OFS_TBCR1:  n_tbcr[15:8] = i_write_data;
                        OFS_ISR:    n_isr = r_isr & ~{1'b0, i_write_data[6:0]};
                        OFS_RSAR0: begin
                            n_rsar[7:0] = i_write_data;
                            n_crda = n_rsar;
                        end
                        OFS_RSAR1: begin
                            n_rsar[15:8] = i_write_data;
                            n_crda = n_rsar;
                        end
                        OFS_RBCR0:  n_rbcr[7:0] = i_write_data;
                        OFS_RBCR1:  n_rbcr[15:8] = i_write_data;
                        OFS_RCR:    n_rcr = i_write_data[5:0];
                        OFS_TCR:    n_tcr = i_write_data[4:0];
                        OFS_DCR:    n_dcr = i_write_data[5:0];
                        default:    n_imr = i_write_data[6:0];
                    endcase
                end else if (page == PAGE1) begin
                    if (ofs <= OFS_TBCR1) begin
                        n_sta[3'(ofs - 4'd1)] = i_write_data;
                    end else if (ofs == OFS_ISR) begin
                        n_curr = i_write_data;
                    end else begin
                        n_mar[ofs[2:0]] = i_write_data;
                    end
                end else if (page == PAGE2) begin
                    case (ofs)
                        OFS_PSTART: n_clda[7:0] = i_write_data;
                        OFS_PSTOP:  n_clda[15:8] = i_write_data;
                        OFS_BNRY:   n_rnpp = i_write_data;
                        OFS_TBCR0:  n_lnpp = i_write_data;
                        OFS_TBCR1:  n_actr[15:8] = i_write_data;
                        OFS_ISR:    n_actr[7:0] = i_write_data;
                        default:    ;
                    endcase
                end
            end else begin
                if (ofs == OFS_CR) begin
                    rd = r_cr;
                end else if (page == PAGE0) begin
                    case (ofs)
                        OFS_PSTART: rd = r_clda[7:0];
                        OFS_PSTOP:  rd = r_clda[15:8];
                        OFS_BNRY:   rd = r_bnry;
                        OFS_TPSR:   rd = 8'h22;
                        OFS_ISR:    rd = r_isr;
                        OFS_RSAR0:  rd = r_crda[7:0];
                        OFS_RSAR1:  rd = r_crda[15:8];
                        OFS_RBCR0:  rd = 8'h50;
                        OFS_RBCR1:  rd = 8'h70;
                        OFS_RCR:    rd = 8'h08;
                        default:    rd = 8'h00;
                    endcase
                end else if (page == PAGE1) begin
                    if (ofs <= OFS_TBCR1) begin
                        rd = r_sta[3'(ofs - 4'd1)];
                    end else if (ofs == OFS_ISR) begin
                        rd = r_curr;
                    end else begin
                        rd = r_mar[ofs[2:0]];
                    end
                end else if (page == PAGE2) begin
                    case (ofs)
                        OFS_PSTART: rd = r_pstart;
                        OFS_PSTOP:  rd = r_pstop;
                        OFS_BNRY:   rd = r_rnpp;
                        OFS_TPSR:   rd = r_tpsr;
                        OFS_TBCR0:  rd = r_lnpp;
                        OFS_TBCR1:  rd = r_actr[15:8];
                        OFS_ISR:    rd = r_actr[7:0];
                        OFS_RCR:    rd = {2'b00, r_rcr};
                        OFS_TCR:    rd = {3'b000, r_tcr};
                        OFS_DCR:    rd = {2'b00, r_dcr};
                        OFS_IMR:    rd = {1'b0, r_imr};
                        default:    rd = 8'hFF;
                    endcase
                end else begin
                    rd = ((ofs == OFS_TBCR0) || (ofs == OFS_TBCR1)) ? 8'h40 : 8'h00;
                end
            end
        end
    end

    always_comb begin
        o_req.rd_en = i_fire && dma_go && in_buf && !i_command;
        o_req.wr_en = i_fire && dma_go && in_buf && i_command;
        o_req.idx   = BUF_AW'(r_crda - 16'(BUFFER_BASE));
        o_req.wdata = i_write_data;
        o_use_mem   = dma_go && in_buf && !i_command;
        o_read_data = i_command ? 8'h00 : rd;
        o_irq       = (n_isr[6:0] & n_imr) != 7'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr <= CR_RESET; r_pstart <= '0; r_pstop <= '0; r_bnry <= '0; r_tpsr <= '0;
            r_isr <= ISR_RESET; r_curr <= '0; r_rnpp <= '0; r_lnpp <= '0; r_tbcr <= '0;
            r_rsar <= '0; r_rbcr <= '0; r_crda <= '0; r_clda <= '0; r_actr <= '0;
            r_rcr <= '0; r_dcr <= '0; r_tcr <= '0; r_imr <= '0;
            for (int k = 0; k < 6; k++) r_sta[k] <= '0;
            for (int k = 0; k < 8; k++) r_mar[k] <= '0;
        end else if (i_fire) begin
            r_cr <= n_cr; r_pstart <= n_pstart; r_pstop <= n_pstop; r_bnry <= n_bnry;
            r_tpsr <= n_tpsr; r_isr <= n_isr; r_curr <= n_curr; r_rnpp <= n_rnpp;
            r_lnpp <= n_lnpp; r_tbcr <= n_tbcr; r_rsar <= n_rsar; r_rbcr <= n_rbcr;
            r_crda <= n_crda; r_clda <= n_clda; r_actr <= n_actr; r_rcr <= n_rcr;
            r_dcr <= n_dcr; r_tcr <= n_tcr; r_imr <= n_imr;
            r_sta <= n_sta; r_mar <= n_mar;
        end
    end

endmodule

// ===== design/ethernet_controller_register_file_unit.sv =====
// Top level of the ethernet controller register file
//   channel | dir | handshake          | fields
//   bus in  | in  | i_valid / o_stall  | i_command, i_address, i_write_data
//   result  | out | o_valid / i_stall  | o_read_data, o_irq
// One beat per cycle while neither o_stall nor i_stall holds the flow; a beat taken
// passes the input register, then the register file update and buffer read into the result
// register, where it shows as valid. After reset the packet buffer is cleared one byte a
// cycle while o_stall is high. A stalled result holds, and the input stage keeps taking
// beats until it is full.
module ethernet_controller_register_file_unit
    import ecrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_command,
    input  logic [4:0] i_address,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic       o_irq
);

    logic       r_v1, r_cmd;
    logic [4:0] r_addr;
    logic [7:0] r_wdata;
    logic       r_v2, r_use_mem, r_irq;
    logic [7:0] r_rd;

    logic       fire, busy, use_mem, irq;
    logic [7:0] rd, mem_q;
    t_buf_req   req;

    assign fire    = r_v1 && (!r_v2 || !i_stall);
    assign o_stall = busy || (r_v1 && !fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r_v1 <= 1'b1;
            end else if (fire) begin
                r_v1 <= 1'b0;
            end
            if (fire) begin
                r_v2 <= 1'b1;
            end else if (!i_stall) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd   <= i_command;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if (fire) begin
            r_rd      <= rd;
            r_use_mem <= use_mem;
            r_irq     <= irq;
        end
    end

    ecrf_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_command    (r_cmd),
        .i_address    (r_addr),
        .i_write_data (r_wdata),
        .o_read_data  (rd),
        .o_use_mem    (use_mem),
        .o_irq        (irq),
        .o_req        (req)
    );

    ecrf_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_q     (mem_q),
        .o_busy  (busy)
    );

    assign o_valid     = r_v2;
    assign o_read_data = r_use_mem ? mem_q : r_rd;
    assign o_irq       = r_irq;

endmodule

// ===== design/ecrf_checker.sv =====
// Port-level checker for the ethernet controller register file
`include "ethernet_controller_register_file_unit_assert.svh"

module ecrf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_read_data,
    input logic       o_irq
);

    logic [2:0] r_pend;
    logic       in_acc, out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {2'b00, in_acc} - {2'b00, out_acc};
        end
    end

    `ECRF_ASSERT_IMP(a_pend_max, 1'b1, r_pend <= 3'd2, "more than two beats in flight")
    `ECRF_ASSERT_IMP(a_no_phantom, o_valid, r_pend != 3'd0, "result without a taken beat")
    `ECRF_ASSERT_IMP(a_full_stall, r_pend == 3'd2 && i_stall, o_stall, "beat taken while full")
    `ECRF_ASSERT_NXT(a_hold, o_valid && i_stall,
        o_valid && $stable(o_read_data) && $stable(o_irq), "stalled result changed")

endmodule

bind ethernet_controller_register_file_unit ecrf_checker u_ecrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_read_data (o_read_data),
    .o_irq       (o_irq)
);

// ===== bench/tb_ethernet_controller_register_file_unit.sv =====
// Testbench of the ethernet controller register file: directed table, then random bus traffic
module tb_ethernet_controller_register_file_unit;
    import ecrf_pkg::*;

    localparam int IDLE_LIMIT = 200000;
    localparam int NUM_RANDOM = 500;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_command = 1'b0;
    logic [4:0] i_address = '0;
    logic [7:0] i_write_data = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_read_data;
    logic       o_irq;

    ethernet_controller_register_file_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
    } t_bus_result;

    typedef struct {
        logic       wr;
        logic [4:0] addr;
        logic [7:0] data;
        logic       typed;
        logic [7:0] rdata;
    } t_access;

    // register file mirror
    logic [7:0]  m_cr, m_pstart, m_pstop, m_bnry, m_tpsr, m_isr;
    logic [15:0] m_tbcr, m_rsar, m_rbcr, m_crda, m_clda, m_ac;
    logic [7:0]  m_rcr, m_tcr, m_dcr, m_imr, m_curr, m_rnpp, m_lnpp;
    logic [7:0]  m_par [6];
    logic [7:0]  m_mar [8];
    logic [7:0]  m_buf [BUFFER_BYTES];

    t_bus_result result_q[$];
    logic [7:0]  typed_q[$];
    logic        typed_flag_q[$];
    int          errors = 0;
    int          idle_cycles = 0;

    function automatic void mirror_reset();
        m_cr = CR_RESET; m_isr = ISR_RESET;
        m_pstart = 0; m_pstop = 0; m_bnry = 0; m_tpsr = 0;
        m_tbcr = 0; m_rsar = 0; m_rbcr = 0; m_crda = 0; m_clda = 0; m_ac = 0;
        m_rcr = 0; m_tcr = 0; m_dcr = 0; m_imr = 0; m_curr = 0; m_rnpp = 0; m_lnpp = 0;
        foreach (m_par[k]) m_par[k] = 0;
        foreach (m_mar[k]) m_mar[k] = 0;
    endfunction

    function automatic logic [7:0] reg_read(logic [3:0] a);
        logic [1:0] pg;
        pg = m_cr[7:6];
        if (a == OFS_CR) return m_cr;
        if (pg == PAGE0) begin
            case (a)
                OFS_PSTART: return m_clda[7:0];
                OFS_PSTOP:  return m_clda[15:8];
                OFS_BNRY:   return m_bnry;
                OFS_TPSR:   return 8'h22;
                OFS_ISR:    return m_isr;
                OFS_RSAR0:  return m_crda[7:0];
                OFS_RSAR1:  return m_crda[15:8];
                OFS_RBCR0:  return 8'h50;
                OFS_RBCR1:  return 8'h70;
                OFS_RCR:    return 8'h08;
                default:    return 8'h00;
            endcase
        end
        if (pg == PAGE1) begin
            if (a <= 6) return m_par[a - 1];
            if (a == 7) return m_curr;
            return m_mar[a - 8];
        end
        if (pg == PAGE2) begin
            case (a)
                OFS_PSTART: return m_pstart;
                OFS_PSTOP:  return m_pstop;
                OFS_BNRY:   return m_rnpp;
                OFS_TPSR:   return m_tpsr;
                OFS_TBCR0:  return m_lnpp;
                OFS_TBCR1:  return m_ac[15:8];
                OFS_ISR:    return m_ac[7:0];
                OFS_RCR:    return m_rcr;
                OFS_TCR:    return m_tcr;
                OFS_DCR:    return m_dcr;
                OFS_IMR:    return m_imr;
                default:    return 8'hFF;
            endcase
        end
        return (a == 5 || a == 6) ? 8'h40 : 8'h00;
    endfunction

    function automatic void reg_write(logic [3:0] a, logic [7:0] v);
        logic [1:0] pg;
        pg = m_cr[7:6];
        if (a == OFS_CR) m_cr = v;
        else if (pg == PAGE0) begin
            case (a)
                OFS_PSTART: m_pstart = v;
                OFS_PSTOP:  m_pstop = v;
                OFS_BNRY:   m_bnry = v;
                OFS_TPSR:   m_tpsr = v;
                OFS_TBCR0:  m_tbcr[7:0] = v;
                OFS_TBCR1:  m_tbcr[15:8] = v;
                OFS_ISR:    m_isr = m_isr & ~{1'b0, v[6:0]};
                OFS_RSAR0:  begin m_rsar[7:0] = v; m_crda = m_rsar; end
                OFS_RSAR1:  begin m_rsar[15:8] = v; m_crda = m_rsar; end
                OFS_RBCR0:  m_rbcr[7:0] = v;
                OFS_RBCR1:  m_rbcr[15:8] = v;
                OFS_RCR:    m_rcr = {2'b0, v[5:0]};
                OFS_TCR:    m_tcr = {3'b0, v[4:0]};
                OFS_DCR:    m_dcr = {2'b0, v[5:0]};
                default:    m_imr = {1'b0, v[6:0]};
            endcase
        end else if (pg == PAGE1) begin
            if (a <= 6) m_par[a - 1] = v;
            else if (a == 7) m_curr = v;
            else m_mar[a - 8] = v;
        end else if (pg == PAGE2) begin
            case (a)
                OFS_PSTART: m_clda[7:0] = v;
                OFS_PSTOP:  m_clda[15:8] = v;
                OFS_BNRY:   m_rnpp = v;
                OFS_TBCR0:  m_lnpp = v;
                OFS_TBCR1:  m_ac[15:8] = v;
                OFS_ISR:    m_ac[7:0] = v;
                default:    ;
            endcase
        end
    endfunction

    function automatic t_bus_result predict_access(logic wr, logic [4:0] a, logic [7:0] v);
        t_bus_result res;
        logic [16:0] ad;
        res.rdata = 8'h00;
        if (a == ADDR_DATA0 || a == ADDR_DATA1) begin
            if (m_rbcr != 0 && !(a[0] && !m_dcr[0])) begin
                ad = {1'b0, m_crda};
                if (ad >= BUF_LO && ad < BUF_HI) begin
                    if (wr) m_buf[ad - BUF_LO] = v;
                    else res.rdata = m_buf[ad - BUF_LO];
                end
                m_crda = m_crda + 16'd1;
                if (m_crda == {m_pstop, 8'h00}) m_crda = {m_pstart, 8'h00};
                m_rbcr = m_rbcr - 16'd1;
                if (m_rbcr == 0) m_isr = m_isr | ISR_RDC;
            end
        end else if (a == ADDR_RESET) begin
            if (!wr) mirror_reset();
        end else if (a < 5'h10) begin
            if (wr) reg_write(a[3:0], v);
            else res.rdata = reg_read(a[3:0]);
        end
        if (wr) res.rdata = 8'h00;
        res.irq = |(m_isr & m_imr);
        return res;
    endfunction

    // directed table
    t_access dir_tab[$];

    task automatic add_row(logic wr, logic [4:0] a, logic [7:0] v, logic typed = 0,
                           logic [7:0] rd = 0);
        t_access r;
        r.wr = wr; r.addr = a; r.data = v; r.typed = typed; r.rdata = rd;
        dir_tab.push_back(r);
    endtask

    task automatic build_table();
        add_row(0, 5'h00, 8'h00, 1, CR_RESET);
        add_row(0, 5'h07, 8'h00, 1, ISR_RESET);
        add_row(0, 5'h0A, 8'h00, 1, 8'h50);
        add_row(0, 5'h10, 8'h00, 1, 8'h00);     // zero count
        add_row(1, 5'h0F, 8'hFF);
        add_row(1, 5'h08, 8'hFE);               // start address 0x7FFE
        add_row(1, 5'h09, 8'h7F);
        add_row(1, 5'h0A, 8'h03);
        add_row(1, 5'h10, 8'hA5);
        add_row(1, 5'h11, 8'h5A);               // odd port in byte mode
        add_row(1, 5'h0E, 8'hFF);
        add_row(1, 5'h11, 8'hFF);
        add_row(1, 5'h10, 8'h00);               // count hits zero
        add_row(1, 5'h07, 8'h7F);
        add_row(1, 5'h00, 8'h40);
        add_row(1, 5'h03, 8'hFF);
        add_row(0, 5'h03, 8'h00, 1, 8'hFF);
        add_row(1, 5'h00, 8'hC0);
        add_row(0, 5'h05, 8'h00, 1, 8'h40);
        add_row(1, 5'h1F, 8'h00);
        add_row(0, 5'h15, 8'h00, 1, 8'h00);
        add_row(0, 5'h1F, 8'h00, 1, 8'h00);
        add_row(0, 5'h00, 8'h00, 1, CR_RESET);
    endtask

    t_access rnd_q[$];

    task automatic add_q(logic wr, logic [4:0] a, logic [7:0] v);
        t_access r;
        r.wr = wr; r.addr = a; r.data = v; r.typed = 0; r.rdata = 0;
        rnd_q.push_back(r);
    endtask

    task automatic build_random();
        int n;
        while (rnd_q.size() < NUM_RANDOM) begin
            n = $urandom_range(0, 9);
            if (n < 3) begin
                // DMA setup then a run on the data ports
                add_q(1, 5'h00, {2'b00, 6'($urandom)});
                add_q(1, 5'h01, 8'($urandom_range(64, 127)));
                add_q(1, 5'h02, 8'($urandom_range(64, 200)));
                add_q(1, 5'h08, 8'($urandom));
                add_q(1, 5'h09, 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(63, 127)));
                add_q(1, 5'h0B, 8'h00);
                add_q(1, 5'h0A, 8'($urandom_range(1, 12)));
                add_q(1, 5'h0E, 8'($urandom));
                repeat ($urandom_range(1, 14))
                    add_q(1'($urandom_range(0, 1)),
                          ($urandom_range(0, 1) != 0) ? ADDR_DATA0 : ADDR_DATA1,
                          8'($urandom));
                if ($urandom_range(0, 3) == 0) add_q(1, 5'h0B, 8'($urandom));
            end else if (n < 8) begin
                add_q(1'($urandom_range(0, 1)), 5'($urandom_range(0, 15)), 8'($urandom));
            end else if (n == 8) begin
                add_q(1'($urandom_range(0, 1)), 5'($urandom), 8'($urandom));
            end else begin
                add_q(0, 5'($urandom_range(1, 15)), 8'($urandom));
            end
        end
    endtask

    // sender
    t_access all_q[$];
    int      send_idx = 0;
    bit      sending_done = 0;
    int      burst = 0;
    int      gap = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) send_idx <= send_idx + 1;
    end

    initial begin : sender
        t_access cur;
        mirror_reset();
        foreach (m_buf[k]) m_buf[k] = 0;
        build_table();
        build_random();
        foreach (dir_tab[k]) all_q.push_back(dir_tab[k]);
        foreach (rnd_q[k]) all_q.push_back(rnd_q[k]);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (send_idx < all_q.size() || i_valid) begin
            @(posedge i_clk);
            if (i_valid && !o_stall) begin
                cur = all_q[send_idx];
                result_q.push_back(predict_access(cur.wr, cur.addr, cur.data));
                typed_flag_q.push_back(cur.typed);
                typed_q.push_back(cur.rdata);
            end
            if (i_valid && o_stall) continue;
            if (burst == 0 && gap == 0) begin
                burst = $urandom_range(1, 20);
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
            end
            if (gap > 0 && burst == 0) begin
                gap--;
                i_valid <= 1'b0;
            end else begin
                if (send_idx + (i_valid && !o_stall ? 1 : 0) < all_q.size()) begin
                    cur = all_q[send_idx + (i_valid && !o_stall ? 1 : 0)];
                    i_valid <= 1'b1;
                    i_command <= cur.wr;
                    i_address <= cur.addr;
                    i_write_data <= cur.data;
                    if (burst > 0) burst--;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
        sending_done = 1;
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if ((stall_phase / 64) % 3 == 0) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 3) == 0) || (stall_phase % 7 == 3);
    end

    // checker
    always @(posedge i_clk) begin
        t_bus_result exp_res;
        logic        is_typed;
        logic [7:0]  typed_val;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                $error("unexpected result beat: read_data %0h irq %0b", o_read_data, o_irq);
                errors++;
            end else begin
                exp_res = result_q.pop_front();
                is_typed = typed_flag_q.pop_front();
                typed_val = typed_q.pop_front();
                if (is_typed && typed_val !== exp_res.rdata) begin
                    $error("read_data table: expected %0h actual %0h", typed_val, exp_res.rdata);
                    errors++;
                end
                if (o_read_data !== exp_res.rdata) begin
                    $error("read_data: expected %0h actual %0h", exp_res.rdata, o_read_data);
                    errors++;
                end
                if (o_irq !== exp_res.irq) begin
                    $error("irq: expected %0b actual %0b", exp_res.irq, o_irq);
                    errors++;
                end
            end
        end
    end

    // watchdog and end of run
    initial begin : finisher
        int tail;
        tail = 0;
        while (!(sending_done && result_q.size() == 0) || tail < 10) begin
            @(posedge i_clk);
            if (sending_done && result_q.size() == 0) tail++;
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_ethernet_controller_register_file_unit: done, errors");
                $finish;
            end
        end
        if (errors == 0 && result_q.size() == 0)
            $display("tb_ethernet_controller_register_file_unit: done, clean");
        else
            $display("tb_ethernet_controller_register_file_unit: done, errors");
        $finish;
    end

endmodule
